>>> rtl/eps_pkg.sv
package eps_pkg;

  localparam int WORD_W     = 32;
  localparam int FRAC_W     = 16;
  localparam int PROD_W     = 2 * WORD_W;
  localparam int SQRT_STEPS = WORD_W;
  localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);
  localparam int CFG_IDX_W  = 3;
  localparam int CFG_DATA_W = 32;

  typedef logic signed [WORD_W-1:0] word_t;
  typedef logic [WORD_W-1:0]        uword_t;
  typedef logic [PROD_W-1:0]        prod_t;

  localparam word_t WORD_MAX = {1'b0, {(WORD_W-1){1'b1}}};
  localparam word_t WORD_MIN = {1'b1, {(WORD_W-1){1'b0}}};

  // step size 0.02 and gravity 9.81, rounded to the fixed point grid
  localparam longint unsigned ONE_Q = 64'd1 << FRAC_W;
  localparam longint unsigned H_RAW = (ONE_Q * 2 + 50) / 100;
  localparam longint unsigned G_RAW = (ONE_Q * 981 + 50) / 100;
  localparam word_t H_Q   = word_t'(H_RAW);
  localparam word_t G_Q   = word_t'(G_RAW);
  localparam word_t NEG_G = word_t'(0) - G_Q;
  localparam uword_t INV_MASS_RST = uword_t'(ONE_Q);

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_RUN_ENABLE,
    REG_DRAG_ENABLE,
    REG_START_POS_X,
    REG_START_POS_Y,
    REG_START_VEL_X,
    REG_START_VEL_Y,
    REG_DRAG_COEFFICIENT,
    REG_INV_MASS
  } reg_idx_t;

  typedef struct packed {
    logic   run_enable;
    logic   drag_enable;
    word_t  start_pos_x;
    word_t  start_pos_y;
    word_t  start_vel_x;
    word_t  start_vel_y;
    uword_t drag_coefficient;
    uword_t inv_mass;
  } cfg_t;

  typedef enum logic [3:0] {
    MUL_NONE,
    MUL_VX_VX,
    MUL_VY_VY,
    MUL_K_SPEED,
    MUL_VX_D,
    MUL_VY_D,
    MUL_VX_H,
    MUL_VY_H,
    MUL_FX_M,
    MUL_FY_M,
    MUL_FX_H,
    MUL_FY_H
  } mul_op_t;

  typedef enum logic [3:0] {
    FIN_NONE,
    FIN_D,
    FIN_FX,
    FIN_FY,
    FIN_PX,
    FIN_PY,
    FIN_AX,
    FIN_AY,
    FIN_VX,
    FIN_VY
  } fin_op_t;

  typedef struct packed {
    logic    clr_clip;
    logic    load;
    logic    zero_force;
    logic    rad_ld;
    logic    sqrt_start;
    logic    sqrt_step;
    mul_op_t mul_op;
    fin_op_t fin_op;
    logic    capture;
  } cmd_t;

  typedef struct packed {
    logic sqrt_done;
  } sts_t;

endpackage

>>> rtl/eps_intf.sv
interface eps_tick_if;
  logic valid;
  logic ready;
  logic restart;
  modport source (output valid, output restart, input ready);
  modport sink (input valid, input restart, output ready);
endinterface

interface eps_result_if;
  import eps_pkg::*;
  logic  valid;
  logic  ready;
  word_t pos_x;
  word_t pos_y;
  word_t vel_x;
  word_t vel_y;
  logic  saturated;
  modport source (output valid, output pos_x, output pos_y, output vel_x, output vel_y,
                  output saturated, input ready);
  modport sink (input valid, input pos_x, input pos_y, input vel_x, input vel_y,
                input saturated, output ready);
endinterface

interface eps_cfg_if;
  import eps_pkg::*;
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;
  modport source (output valid, output index, output data, input ready);
  modport sink (input valid, input index, input data, output ready);
endinterface

>>> rtl/eps_cfg.sv
module eps_cfg (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           wr_en,
  input  logic [eps_pkg::CFG_IDX_W-1:0]  wr_index,
  input  logic [eps_pkg::CFG_DATA_W-1:0] wr_data,
  output eps_pkg::cfg_t                  regs
);
  import eps_pkg::*;

  always_ff @(posedge clk) begin
    if (rst) begin
      regs.run_enable       <= 1'b1;
      regs.drag_enable      <= 1'b0;
      regs.start_pos_x      <= '0;
      regs.start_pos_y      <= '0;
      regs.start_vel_x      <= '0;
      regs.start_vel_y      <= '0;
      regs.drag_coefficient <= '0;
      regs.inv_mass         <= INV_MASS_RST;
    end else if (wr_en) begin
      unique case (reg_idx_t'(wr_index))
        REG_RUN_ENABLE:       regs.run_enable       <= wr_data[0];
        REG_DRAG_ENABLE:      regs.drag_enable      <= wr_data[0];
        REG_START_POS_X:      regs.start_pos_x      <= word_t'(wr_data);
        REG_START_POS_Y:      regs.start_pos_y      <= word_t'(wr_data);
        REG_START_VEL_X:      regs.start_vel_x      <= word_t'(wr_data);
        REG_START_VEL_Y:      regs.start_vel_y      <= word_t'(wr_data);
        REG_DRAG_COEFFICIENT: regs.drag_coefficient <= uword_t'(wr_data);
        REG_INV_MASS:         regs.inv_mass         <= uword_t'(wr_data);
        default: ;
      endcase
    end
  end

endmodule

>>> rtl/eps_ctrl.sv
module eps_ctrl (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  input  logic          in_restart,
  output logic          in_ready,
  output logic          out_valid,
  input  logic          out_ready,
  input  logic          run_enable,
  input  logic          drag_enable,
  output eps_pkg::cmd_t cmd,
  input  eps_pkg::sts_t sts
);
  import eps_pkg::*;

  typedef enum logic [4:0] {
    S_IDLE,
    S_LOAD,
    S_NODRAG,
    S_SQ_X,
    S_SQ_Y,
    S_RAD,
    S_SQRT,
    S_MKS,
    S_FIN_D,
    S_MVXD,
    S_MVYD,
    S_FFY_MVXH,
    S_MVYH,
    S_MFXM,
    S_MFYM,
    S_MFXH,
    S_MFYH,
    S_FIN_VY,
    S_DONE
  } state_t;

  state_t state, state_next;
  logic   loaded;

  assign in_ready = (state == S_IDLE);

  always_comb begin
    state_next = state;
    cmd        = '0;
    unique case (state)
      S_IDLE: begin
        if (in_valid) begin
          cmd.clr_clip = 1'b1;
          if (!run_enable) begin
            state_next = S_DONE;
          end else if (in_restart || !loaded) begin
            state_next = S_LOAD;
          end else begin
            state_next = drag_enable ? S_SQ_X : S_NODRAG;
          end
        end
      end
      S_LOAD: begin
        cmd.load   = 1'b1;
        state_next = drag_enable ? S_SQ_X : S_NODRAG;
      end
      S_NODRAG: begin
        cmd.zero_force = 1'b1;
        cmd.mul_op     = MUL_VX_H;
        state_next     = S_MVYH;
      end
      S_SQ_X: begin
        cmd.mul_op = MUL_VX_VX;
        state_next = S_SQ_Y;
      end
      S_SQ_Y: begin
        cmd.mul_op = MUL_VY_VY;
        cmd.rad_ld = 1'b1;
        state_next = S_RAD;
      end
      S_RAD: begin
        cmd.sqrt_start = 1'b1;
        state_next     = S_SQRT;
      end
      S_SQRT: begin
        cmd.sqrt_step = 1'b1;
        if (sts.sqrt_done) begin
          state_next = S_MKS;
        end
      end
      S_MKS: begin
        cmd.mul_op = MUL_K_SPEED;
        state_next = S_FIN_D;
      end
      S_FIN_D: begin
        cmd.fin_op = FIN_D;
        state_next = S_MVXD;
      end
      S_MVXD: begin
        cmd.mul_op = MUL_VX_D;
        state_next = S_MVYD;
      end
      // each state below, up to S_MFYH, finishes the previous product while starting the next
      S_MVYD: begin
        cmd.mul_op = MUL_VY_D;
        cmd.fin_op = FIN_FX;
        state_next = S_FFY_MVXH;
      end
      S_FFY_MVXH: begin
        cmd.mul_op = MUL_VX_H;
        cmd.fin_op = FIN_FY;
        state_next = S_MVYH;
      end
      S_MVYH: begin
        cmd.mul_op = MUL_VY_H;
        cmd.fin_op = FIN_PX;
        state_next = S_MFXM;
      end
      S_MFXM: begin
        cmd.mul_op = MUL_FX_M;
        cmd.fin_op = FIN_PY;
        state_next = S_MFYM;
      end
      S_MFYM: begin
        cmd.mul_op = MUL_FY_M;
        cmd.fin_op = FIN_AX;
        state_next = S_MFXH;
      end
      S_MFXH: begin
        cmd.mul_op = MUL_FX_H;
        cmd.fin_op = FIN_AY;
        state_next = S_MFYH;
      end
      S_MFYH: begin
        cmd.mul_op = MUL_FY_H;
        cmd.fin_op = FIN_VX;
        state_next = S_FIN_VY;
      end
      S_FIN_VY: begin
        cmd.fin_op = FIN_VY;
        state_next = S_DONE;
      end
      S_DONE: begin
        if (!out_valid || out_ready) begin
          cmd.capture = 1'b1;
          state_next  = S_IDLE;
        end
      end
      default: state_next = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      loaded    <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == S_LOAD) begin
        loaded <= 1'b1;
      end
      if (cmd.capture) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

endmodule

>>> rtl/eps_dp.sv
module eps_dp (
  input  logic           clk,
  input  logic           rst,
  input  eps_pkg::cmd_t  cmd,
  input  eps_pkg::cfg_t  regs,
  output eps_pkg::sts_t  sts,
  output eps_pkg::word_t pos_x,
  output eps_pkg::word_t pos_y,
  output eps_pkg::word_t vel_x,
  output eps_pkg::word_t vel_y,
  output logic           saturated
);
  import eps_pkg::*;

  localparam int MAG_W = PROD_W - FRAC_W;
  localparam logic [MAG_W-1:0] POS_LIM = {{(MAG_W-WORD_W){1'b0}}, WORD_MAX};
  localparam logic [MAG_W-1:0] NEG_LIM = POS_LIM + 1'b1;

  typedef logic signed [WORD_W:0] sum_t;

  function automatic uword_t mag_of(input word_t v);
    mag_of = v[WORD_W-1] ? (~uword_t'(v) + uword_t'(1)) : uword_t'(v);
  endfunction

  // architectural state
  word_t  px, py, vx, vy;
  // working registers
  word_t  fx, fy;
  uword_t drag_d;
  prod_t  p;
  logic   p_neg;
  prod_t  rad;
  logic   clip;

  // square root unit
  prod_t                 sq_rad;
  logic [WORD_W+1:0]     sq_rem;
  uword_t                sq_root;
  logic [SQRT_CNT_W-1:0] sq_cnt;
  logic [WORD_W+3:0]     sq_cur, sq_trial, sq_diff;
  logic                  sq_ge;

  uword_t mul_a, mul_b;
  logic   mul_neg;

  logic [MAG_W-1:0] mag_q;
  word_t            s_val;
  logic             s_clip;
  word_t            fin_base;
  logic             fin_sub;
  sum_t             fin_sum;
  logic             fin_ovf;
  word_t            fin_val;
  logic             d_ovf;
  uword_t           d_val;
  logic             fin_clip;

  assign sts.sqrt_done = (sq_cnt == '1);

  // restoring square root, two radicand bits per step
  assign sq_cur   = {sq_rem, sq_rad[PROD_W-1 -: 2]};
  assign sq_trial = {2'b00, sq_root, 2'b01};
  assign sq_ge    = (sq_cur >= sq_trial);
  assign sq_diff  = sq_cur - sq_trial;

  always_comb begin
    mul_a   = '0;
    mul_b   = '0;
    mul_neg = 1'b0;
    unique case (cmd.mul_op)
      MUL_VX_VX: begin
        mul_a = mag_of(vx);
        mul_b = mag_of(vx);
      end
      MUL_VY_VY: begin
        mul_a = mag_of(vy);
        mul_b = mag_of(vy);
      end
      MUL_K_SPEED: begin
        mul_a = regs.drag_coefficient;
        mul_b = sq_root;
      end
      MUL_VX_D: begin
        mul_a   = mag_of(vx);
        mul_b   = drag_d;
        mul_neg = vx[WORD_W-1];
      end
      MUL_VY_D: begin
        mul_a   = mag_of(vy);
        mul_b   = drag_d;
        mul_neg = vy[WORD_W-1];
      end
      MUL_VX_H: begin
        mul_a   = mag_of(vx);
        mul_b   = uword_t'(H_Q);
        mul_neg = vx[WORD_W-1];
      end
      MUL_VY_H: begin
        mul_a   = mag_of(vy);
        mul_b   = uword_t'(H_Q);
        mul_neg = vy[WORD_W-1];
      end
      MUL_FX_M: begin
        mul_a   = mag_of(fx);
        mul_b   = regs.inv_mass;
        mul_neg = fx[WORD_W-1];
      end
      MUL_FY_M: begin
        mul_a   = mag_of(fy);
        mul_b   = regs.inv_mass;
        mul_neg = fy[WORD_W-1];
      end
      MUL_FX_H: begin
        mul_a   = mag_of(fx);
        mul_b   = uword_t'(H_Q);
        mul_neg = fx[WORD_W-1];
      end
      MUL_FY_H: begin
        mul_a   = mag_of(fy);
        mul_b   = uword_t'(H_Q);
        mul_neg = fy[WORD_W-1];
      end
      default: ;
    endcase
  end

  // scaled product back to a signed word, clipping the magnitude
  assign mag_q = p[PROD_W-1:FRAC_W];

  always_comb begin
    s_clip = 1'b0;
    if (!p_neg) begin
      if (mag_q > POS_LIM) begin
        s_val  = WORD_MAX;
        s_clip = 1'b1;
      end else begin
        s_val = word_t'(mag_q[WORD_W-1:0]);
      end
    end else begin
      if (mag_q > NEG_LIM) begin
        s_val  = WORD_MIN;
        s_clip = 1'b1;
      end else begin
        s_val = word_t'(~mag_q[WORD_W-1:0] + 1'b1);
      end
    end
  end

  always_comb begin
    fin_base = '0;
    fin_sub  = 1'b0;
    unique case (cmd.fin_op)
      FIN_FX: fin_sub = 1'b1;
      FIN_FY: begin
        fin_base = NEG_G;
        fin_sub  = 1'b1;
      end
      FIN_PX: fin_base = px;
      FIN_PY: fin_base = py;
      FIN_VX: fin_base = vx;
      FIN_VY: fin_base = vy;
      default: ;
    endcase
  end

  assign fin_sum = fin_sub ? (sum_t'(fin_base) - sum_t'(s_val))
                           : (sum_t'(fin_base) + sum_t'(s_val));
  assign fin_ovf = (fin_sum[WORD_W] != fin_sum[WORD_W-1]);
  assign fin_val = fin_ovf ? (fin_sum[WORD_W] ? WORD_MIN : WORD_MAX)
                           : word_t'(fin_sum[WORD_W-1:0]);

  // drag factor stays unsigned, clipped to the word
  assign d_ovf    = |p[PROD_W-1:FRAC_W+WORD_W];
  assign d_val    = d_ovf ? '1 : p[FRAC_W+WORD_W-1:FRAC_W];
  assign fin_clip = (cmd.fin_op == FIN_D) ? d_ovf : (s_clip | fin_ovf);

  always_ff @(posedge clk) begin
    if (rst) begin
      px <= '0;
      py <= '0;
      vx <= '0;
      vy <= '0;
    end else if (cmd.load) begin
      px <= regs.start_pos_x;
      py <= regs.start_pos_y;
      vx <= regs.start_vel_x;
      vy <= regs.start_vel_y;
    end else begin
      unique case (cmd.fin_op)
        FIN_PX: px <= fin_val;
        FIN_PY: py <= fin_val;
        FIN_VX: vx <= fin_val;
        FIN_VY: vy <= fin_val;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.clr_clip) begin
      clip <= 1'b0;
    end else if (cmd.fin_op != FIN_NONE) begin
      clip <= clip | fin_clip;
    end

    if (cmd.mul_op != MUL_NONE) begin
      p     <= prod_t'(mul_a) * prod_t'(mul_b);
      p_neg <= mul_neg;
    end

    if (cmd.zero_force) begin
      fx <= '0;
      fy <= NEG_G;
    end else begin
      unique case (cmd.fin_op) inside
        FIN_D:          drag_d <= d_val;
        FIN_FX, FIN_AX: fx     <= fin_val;
        FIN_FY, FIN_AY: fy     <= fin_val;
        default: ;
      endcase
    end

    if (cmd.rad_ld) begin
      rad <= p;
    end

    if (cmd.sqrt_start) begin
      sq_rad  <= rad + p;
      sq_rem  <= '0;
      sq_root <= '0;
      sq_cnt  <= '0;
    end else if (cmd.sqrt_step) begin
      sq_rem  <= sq_ge ? sq_diff[WORD_W+1:0] : sq_cur[WORD_W+1:0];
      sq_root <= {sq_root[WORD_W-2:0], sq_ge};
      sq_rad  <= {sq_rad[PROD_W-3:0], 2'b00};
      sq_cnt  <= sq_cnt + 1'b1;
    end

    if (cmd.capture) begin
      pos_x     <= px;
      pos_y     <= py;
      vel_x     <= vx;
      vel_y     <= vy;
      saturated <= clip;
    end
  end

endmodule

>>> rtl/euler_projectile_drag_step.sv
// One explicit Euler step (h = 0.02) of a 2D point mass per tick, Q16.16 with
// saturation: gravity always, quadratic drag k*|v|*v when drag_enable is set.
// The first running tick after reset, or a tick with restart, first reloads the
// start registers; with run_enable low a tick returns the held state. Ticks are
// handled one at a time. With drag, |v| comes from the 32-step square root;
// everything else goes through a single shared 32x32 multiplier, at most one
// product per cycle. The result sits in an output register, so the next tick is
// taken while it waits. Configuration writes are taken every cycle and belong
// between ticks.
module euler_projectile_drag_step (
  input  logic clk,
  input  logic rst,
  eps_tick_if.sink     tick,
  eps_result_if.source result,
  eps_cfg_if.sink      cfg
);
  import eps_pkg::*;

  cfg_t cfg_regs;
  cmd_t cmd;
  sts_t sts;

  assign cfg.ready = 1'b1;

  eps_cfg u_cfg (
    .clk      (clk),
    .rst      (rst),
    .wr_en    (cfg.valid),
    .wr_index (cfg.index),
    .wr_data  (cfg.data),
    .regs     (cfg_regs)
  );

  eps_ctrl u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (tick.valid),
    .in_restart  (tick.restart),
    .in_ready    (tick.ready),
    .out_valid   (result.valid),
    .out_ready   (result.ready),
    .run_enable  (cfg_regs.run_enable),
    .drag_enable (cfg_regs.drag_enable),
    .cmd         (cmd),
    .sts         (sts)
  );

  eps_dp u_dp (
    .clk       (clk),
    .rst       (rst),
    .cmd       (cmd),
    .regs      (cfg_regs),
    .sts       (sts),
    .pos_x     (result.pos_x),
    .pos_y     (result.pos_y),
    .vel_x     (result.vel_x),
    .vel_y     (result.vel_y),
    .saturated (result.saturated)
  );

endmodule

>>> rtl/eps_checker.sv
module eps_checker (
  input logic           clk,
  input logic           rst,
  input logic           tick_valid,
  input logic           tick_ready,
  input logic           res_valid,
  input logic           res_ready,
  input eps_pkg::word_t res_pos_x,
  input eps_pkg::word_t res_pos_y,
  input eps_pkg::word_t res_vel_x,
  input eps_pkg::word_t res_vel_y,
  input logic           res_saturated
);

  a_reset_clears: assert property (@(posedge clk) rst |=> !res_valid)
    else $error("result valid after reset");

  // one tick at a time: the block is busy right after a transfer
  a_one_in_flight: assert property (@(posedge clk) disable iff (rst)
    (tick_valid && tick_ready) |=> !tick_ready)
    else $error("tick taken while another is in work");

  a_result_from_work: assert property (@(posedge clk) disable iff (rst)
    $rose(res_valid) |-> $past(!tick_ready))
    else $error("result appeared while idle");

  a_result_holds: assert property (@(posedge clk) disable iff (rst)
    (res_valid && !res_ready) |=> (res_valid && $stable(res_pos_x) &&
      $stable(res_pos_y) && $stable(res_vel_x) && $stable(res_vel_y) &&
      $stable(res_saturated)))
    else $error("stalled result changed");

endmodule

bind euler_projectile_drag_step eps_checker u_eps_checker (
  .clk           (clk),
  .rst           (rst),
  .tick_valid    (tick.valid),
  .tick_ready    (tick.ready),
  .res_valid     (result.valid),
  .res_ready     (result.ready),
  .res_pos_x     (result.pos_x),
  .res_pos_y     (result.pos_y),
  .res_vel_x     (result.vel_x),
  .res_vel_y     (result.vel_y),
  .res_saturated (result.saturated)
);
